// ----- rtl/pts_pkg.sv -----
// package for the periodic task scheduler
// holds the opcodes, status codes and the control structs shared by the rtl modules
// no dependencies

package pts_pkg;

   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_ADD      = 3'd1;
   localparam logic [2:0] OP_SCHEDULE = 3'd2;
   localparam logic [2:0] OP_CANCEL   = 3'd3;
   localparam logic [2:0] OP_EDIT     = 3'd4;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN_ID = 2'd2;

   localparam int MASK_BITS   = 16;
   localparam int PERIOD_W    = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   typedef struct packed {
      logic wr_period;
      logic wr_arrival;
      logic set_sched;
      logic clr_sched;
   } tbl_cmd_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } mod_status_type;

endpackage

// ----- rtl/periodic_task_scheduler_top.sv -----
// periodic task scheduler top level, depends on pts_pkg, pts_table and pts_mod
// add, schedule, cancel, edit and unknown ops: response registered, valid in the cycle after the request
// tick: walks each allocated task (at most 16) through the read and check states, and also
//   through the divide state when the task can be due and the serial modulo runs
// one request at a time; the modulo unit and the table read port set the tick length
// sync reset clears timer, next id, scheduled flags, sets tick_step to 1; memories not cleared

module periodic_task_scheduler_top
   import pts_pkg::*;
#(
   parameter int NUM_TASKS   = 16,
   parameter int TIMER_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // op [2:0], task_id [6:3], interval [22:7], zero [23]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status [1:0], new_id [5:2], due_mask [21:6], zero [23:22]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [7:0]             csr_wdata
);

   localparam int IDX_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int NFREE_W = $clog2(NUM_TASKS + 1);
   localparam int CMP_W   = (NFREE_W > 4) ? NFREE_W : 4;
   localparam int WALK_MAX = (NUM_TASKS < MASK_BITS) ? NUM_TASKS : MASK_BITS;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_DIV   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [NFREE_W-1:0]     nfree_ff, nfree_in;
   logic [7:0]             step_ff;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [MASK_BITS-1:0]   mask_ff, mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic [3:0]             new_id_ff, new_id_in;
   logic [MASK_BITS-1:0]   due_ff, due_in;

   logic [2:0]             req_op;
   logic [3:0]             req_id;
   logic [PERIOD_W-1:0]    req_interval;
   logic                   req_fire;
   logic                   known;
   logic                   full;
   logic [NFREE_W-1:0]     walk_limit;
   logic                   walk_last;
   logic [NFREE_W-1:0]     k_ext;
   logic [3:0]             k_bit;

   tbl_cmd_type            tbl_cmd;
   logic [IDX_W-1:0]       tbl_wr_addr;
   logic [PERIOD_W-1:0]    rd_period;
   logic [TIMER_WIDTH-1:0] rd_arrival;
   logic                   rd_sched;
   logic [TIMER_WIDTH-1:0] elapsed;
   logic                   mod_start;
   mod_status_type         mod_st;

   assign req_op       = req_tdata[2:0];
   assign req_id       = req_tdata[6:3];
   assign req_interval = req_tdata[22:7];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign known = CMP_W'(req_id) < CMP_W'(nfree_ff);
   assign full  = (nfree_ff == NFREE_W'(NUM_TASKS));

   assign walk_limit = (nfree_ff < NFREE_W'(WALK_MAX)) ? nfree_ff : NFREE_W'(WALK_MAX);
   assign k_ext      = NFREE_W'(k_ff);
   assign walk_last  = (k_ext + 1'b1) == walk_limit;
   assign k_bit      = 4'(k_ff);
   assign elapsed    = timer_ff - rd_arrival;

   pts_table #(
      .NUM_TASKS  (NUM_TASKS),
      .TIMER_WIDTH(TIMER_WIDTH),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .cmd          (tbl_cmd),
      .wr_addr      (tbl_wr_addr),
      .wr_period    (req_interval),
      .wr_arrival   (timer_ff),
      .rd_addr      (k_ff),
      .rd_period_ff (rd_period),
      .rd_arrival_ff(rd_arrival),
      .rd_sched_ff  (rd_sched)
   );

   pts_mod #(
      .DATA_W(TIMER_WIDTH)
   ) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .dividend(elapsed),
      .divisor (rd_period),
      .status  (mod_st)
   );

   // request decode and table writes
   always_comb begin
      tbl_cmd     = '0;
      tbl_wr_addr = IDX_W'(req_id);
      nfree_in    = nfree_ff;
      status_in   = STATUS_OK;
      new_id_in   = '0;
      if (req_fire) begin
         unique case (req_op)
            OP_ADD: begin
               tbl_wr_addr = IDX_W'(nfree_ff);
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  tbl_cmd.wr_period  = 1'b1;
                  tbl_cmd.wr_arrival = 1'b1;
                  tbl_cmd.clr_sched  = 1'b1;
                  new_id_in          = 4'(nfree_ff);
                  nfree_in           = nfree_ff + 1'b1;
               end
            end
            OP_SCHEDULE, OP_CANCEL, OP_EDIT: begin
               if (!known) begin
                  status_in = STATUS_UNKNOWN_ID;
               end else if (req_op == OP_SCHEDULE) begin
                  tbl_cmd.set_sched  = 1'b1;
                  tbl_cmd.wr_arrival = 1'b1;
               end else if (req_op == OP_CANCEL) begin
                  tbl_cmd.clr_sched = 1'b1;
               end else begin
                  tbl_cmd.wr_period  = 1'b1;
                  tbl_cmd.wr_arrival = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // tick walk sequencer and response register
   always_comb begin
      state_in     = state_ff;
      timer_in     = timer_ff;
      k_in         = k_ff;
      mask_in      = mask_ff;
      mod_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      due_in       = due_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_TICK && walk_limit != '0) begin
                  state_in = ST_READ;
                  k_in     = '0;
                  mask_in  = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  due_in       = '0;
                  if (req_op == OP_TICK) begin
                     timer_in = timer_ff + TIMER_WIDTH'(step_ff);
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_sched && rd_period != '0 && elapsed != '0) begin
               mod_start = 1'b1;
               state_in  = ST_DIV;
            end else if (walk_last) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               due_in       = mask_ff;
               timer_in     = timer_ff + TIMER_WIDTH'(step_ff);
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (mod_st.done) begin
               if (mod_st.rem_zero) begin
                  mask_in = mask_ff | (MASK_BITS'(1) << k_bit);
               end
               if (walk_last) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  due_in       = mask_in;
                  timer_in     = timer_ff + TIMER_WIDTH'(step_ff);
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timer_ff     <= '0;
         nfree_ff     <= '0;
         step_ff      <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timer_ff     <= timer_in;
         nfree_ff     <= nfree_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      mask_ff <= mask_in;
      due_ff  <= due_in;
      if (req_fire) begin
         status_ff <= status_in;
         new_id_ff <= new_id_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, due_ff, new_id_ff, status_ff};

   // modulo results only arrive while the sequencer waits for them
   assert property (@(posedge clock) disable iff (reset)
      mod_st.done |-> state_ff == ST_DIV)
      else $error("modulo done outside divide state");

   // the walk never addresses a task beyond the walk limit
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> k_ext < walk_limit)
      else $error("tick walk index out of range");

   // a request other than a tick answers in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op != OP_TICK |=> rsp_tvalid && state_ff == ST_IDLE)
      else $error("missing single-cycle response");

   // allocation never runs past the table
   assert property (@(posedge clock) disable iff (reset)
      nfree_ff <= NFREE_W'(NUM_TASKS))
      else $error("next free id beyond table");

endmodule

// ----- rtl/pts_table.sv -----
// task table: period and arrival memories with registered reads,
// scheduled flags in flip-flops cleared by reset
// depends on pts_pkg

module pts_table
   import pts_pkg::*;
#(
   parameter int NUM_TASKS   = 16,
   parameter int TIMER_WIDTH = 32,
   parameter int IDX_W       = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tbl_cmd_type            cmd,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [PERIOD_W-1:0]    wr_period,
   input  logic [TIMER_WIDTH-1:0] wr_arrival,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [PERIOD_W-1:0]    rd_period_ff,
   output logic [TIMER_WIDTH-1:0] rd_arrival_ff,
   output logic                   rd_sched_ff
);

   logic [PERIOD_W-1:0]    period_mem  [NUM_TASKS];
   logic [TIMER_WIDTH-1:0] arrival_mem [NUM_TASKS];
   logic [NUM_TASKS-1:0]   sched_ff;
   logic [NUM_TASKS-1:0]   sched_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_period) begin
         period_mem[wr_addr] <= wr_period;
      end
      if (cmd.wr_arrival) begin
         arrival_mem[wr_addr] <= wr_arrival;
      end
      rd_period_ff  <= period_mem[rd_addr];
      rd_arrival_ff <= arrival_mem[rd_addr];
      rd_sched_ff   <= sched_ff[rd_addr];
   end

   always_comb begin
      sched_in = sched_ff;
      if (cmd.set_sched) begin
         sched_in[wr_addr] = 1'b1;
      end
      if (cmd.clr_sched) begin
         sched_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sched_ff <= '0;
      end else begin
         sched_ff <= sched_in;
      end
   end

endmodule

// ----- rtl/pts_mod.sv -----
// serial restoring modulo unit, one quotient bit per cycle
// reports whether the remainder of dividend by a 16-bit divisor is zero
// depends on pts_pkg

module pts_mod
   import pts_pkg::*;
#(
   parameter int DATA_W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DATA_W-1:0]   dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output mod_status_type      status
);

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0]   quo_ff;
   logic [PERIOD_W-1:0] rem_ff;
   logic [PERIOD_W-1:0] rem_in;
   logic [PERIOD_W-1:0] div_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [PERIOD_W:0]   trial;

   always_comb begin
      trial = {rem_ff, quo_ff[DATA_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = PERIOD_W'(trial - {1'b0, div_ff});
      end else begin
         rem_in = trial[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

// ----- sim/tb_periodic_task_scheduler_top.sv -----
// self-checking bench for periodic_task_scheduler_top: directed table, then random requests
// checked against a behavioral copy of the task table, timer and tick step kept in this file
// depends on pts_pkg and the rtl of periodic_task_scheduler_top
`timescale 1ns / 100ps

module tb_periodic_task_scheduler_top;
   import pts_pkg::*;

   localparam int NUM_TASKS   = 16;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SEG_ITEMS   = 90;
   localparam int HOLD_CYCLES = 1500;

   localparam logic [2:0] OP_UNDEF_A = 3'd5;
   localparam logic [2:0] OP_UNDEF_B = 3'd6;
   localparam logic [2:0] OP_UNDEF_C = 3'd7;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  new_id;
      logic [15:0] due_mask;
   } sched_reply_type;

   typedef struct {
      logic [2:0]      op;
      logic [3:0]      task_id;
      logic [15:0]     interval;
      bit              typed;
      sched_reply_type reply;
   } dir_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [7:0]             csr_wdata;

   // task table copy
   logic [31:0] tbl_timer;
   logic [4:0]  tbl_next_id;
   logic [7:0]  tbl_step;
   logic [15:0] tbl_period [NUM_TASKS];
   logic [31:0] tbl_arrival [NUM_TASKS];
   logic [15:0] tbl_sched;

   sched_reply_type sched_reply_q [$];

   bit              row_typed;
   sched_reply_type row_reply;
   int              send_idle;
   int              recv_idle;
   bit              rsp_hold_req;
   int              rsp_hold_left;
   int              cycle_count;
   int              mismatch_count;
   int              request_count;
   int              tick_count;
   int              due_flag_count;
   int              full_count;
   int              unknown_count;

   dir_row_type dir_rows [25] = '{
      '{OP_TICK,     4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_SCHEDULE, 4'd0,  16'h0000, 1'b1, '{STATUS_UNKNOWN_ID, 4'd0, 16'h0000}},
      '{OP_CANCEL,   4'd15, 16'h0000, 1'b1, '{STATUS_UNKNOWN_ID, 4'd0, 16'h0000}},
      '{OP_EDIT,     4'd0,  16'hFFFF, 1'b1, '{STATUS_UNKNOWN_ID, 4'd0, 16'h0000}},
      '{OP_UNDEF_A,  4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_UNDEF_B,  4'd15, 16'hFFFF, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_UNDEF_C,  4'd15, 16'hFFFF, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_ADD,      4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_ADD,      4'd15, 16'hFFFF, 1'b1, '{STATUS_OK,         4'd1, 16'h0000}},
      '{OP_ADD,      4'd0,  16'h0001, 1'b1, '{STATUS_OK,         4'd2, 16'h0000}},
      '{OP_ADD,      4'd0,  16'h0003, 1'b1, '{STATUS_OK,         4'd3, 16'h0000}},
      '{OP_SCHEDULE, 4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_SCHEDULE, 4'd1,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_SCHEDULE, 4'd2,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_SCHEDULE, 4'd3,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_TICK,     4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_TICK,     4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0004}},
      '{OP_TICK,     4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h0004}},
      '{OP_TICK,     4'd0,  16'h0000, 1'b1, '{STATUS_OK,         4'd0, 16'h000C}},
      '{OP_EDIT,     4'd3,  16'h0002, 1'b0, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_CANCEL,   4'd2,  16'h0000, 1'b0, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_TICK,     4'd0,  16'h0000, 1'b0, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_TICK,     4'd0,  16'h0000, 1'b0, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_TICK,     4'd0,  16'h0000, 1'b0, '{STATUS_OK,         4'd0, 16'h0000}},
      '{OP_SCHEDULE, 4'd4,  16'h0000, 1'b1, '{STATUS_UNKNOWN_ID, 4'd0, 16'h0000}}
   };

   logic [7:0] seg_steps [6] = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2, 8'd255};

   periodic_task_scheduler_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sched_reply_type apply_sched_op(input logic [2:0] op,
                                                      input logic [3:0] id,
                                                      input logic [15:0] ival);
      sched_reply_type r;
      logic [31:0]     elapsed;
      bit              known;
      r     = '0;
      known = {1'b0, id} < tbl_next_id;
      case (op)
         OP_TICK: begin
            for (int k = 0; k < NUM_TASKS; k++) begin
               elapsed = tbl_timer - tbl_arrival[k];
               if (k < tbl_next_id && tbl_sched[k] && tbl_period[k] != 0 && elapsed != 0 &&
                   elapsed % {16'd0, tbl_period[k]} == 0)
                  r.due_mask[k] = 1'b1;
            end
            tbl_timer = tbl_timer + {24'd0, tbl_step};
         end
         OP_ADD: begin
            if (tbl_next_id >= NUM_TASKS) begin
               r.status = STATUS_FULL;
            end else begin
               tbl_period[tbl_next_id]  = ival;
               tbl_arrival[tbl_next_id] = tbl_timer;
               tbl_sched[tbl_next_id]   = 1'b0;
               r.new_id                 = tbl_next_id[3:0];
               tbl_next_id              = tbl_next_id + 1'b1;
            end
         end
         OP_SCHEDULE, OP_CANCEL, OP_EDIT: begin
            if (!known) begin
               r.status = STATUS_UNKNOWN_ID;
            end else if (op == OP_SCHEDULE) begin
               tbl_sched[id]   = 1'b1;
               tbl_arrival[id] = tbl_timer;
            end else if (op == OP_CANCEL) begin
               tbl_sched[id] = 1'b0;
            end else begin
               tbl_period[id]  = ival;
               tbl_arrival[id] = tbl_timer;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < 40)
         $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // checker: predicts on each accepted request, compares each accepted response
   always @(posedge clock) begin
      sched_reply_type got;
      sched_reply_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count,
                  sched_reply_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
      if (reset) begin
         tbl_timer   = '0;
         tbl_next_id = '0;
         tbl_step    = 8'd1;
         tbl_sched   = '0;
         for (int k = 0; k < NUM_TASKS; k++) begin
            tbl_period[k]  = '0;
            tbl_arrival[k] = '0;
         end
      end else begin
         if (csr_we)
            tbl_step = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tdata[1:0];
            got.new_id   = rsp_tdata[5:2];
            got.due_mask = rsp_tdata[21:6];
            if (sched_reply_q.size() == 0) begin
               report_mismatch("unrequested response", 16'(got), 16'h0);
            end else begin
               want = sched_reply_q.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 16'(got.status), 16'(want.status));
               if (got.new_id != want.new_id)
                  report_mismatch("new_id", 16'(got.new_id), 16'(want.new_id));
               if (got.due_mask != want.due_mask)
                  report_mismatch("due_mask", got.due_mask, want.due_mask);
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_sched_op(req_tdata[2:0], req_tdata[6:3], req_tdata[22:7]);
            if (row_typed)
               want = row_reply;
            sched_reply_q = {sched_reply_q, want};
            request_count++;
            if (req_tdata[2:0] == OP_TICK)
               tick_count++;
            due_flag_count += $countones(want.due_mask);
            if (want.status == STATUS_FULL)
               full_count++;
            if (want.status == STATUS_UNKNOWN_ID)
               unknown_count++;
         end
      end
   end

   // response side backpressure, with an optional long hold-off
   always @(negedge clock) begin
      if (rsp_hold_req) begin
         rsp_hold_left = HOLD_CYCLES;
         rsp_hold_req  = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [3:0] id,
                               input logic [15:0] ival, input bit typed,
                               input sched_reply_type reply);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, ival, id, op};
      row_typed  = typed;
      row_reply  = reply;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sched_reply_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_tick_step(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [2:0]  op;
      logic [3:0]  id;
      logic [15:0] ival;
      int          pick;
      int          mult;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      row_typed      = 1'b0;
      row_reply      = '0;
      send_idle      = 13;
      recv_idle      = 54;
      rsp_hold_req   = 1'b0;
      rsp_hold_left  = 0;
      cycle_count    = 0;
      mismatch_count = 0;
      request_count  = 0;
      tick_count     = 0;
      due_flag_count = 0;
      full_count     = 0;
      unknown_count  = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_tick_step(8'd1);

      foreach (dir_rows[i])
         send_request(dir_rows[i].op, dir_rows[i].task_id, dir_rows[i].interval,
                      dir_rows[i].typed, dir_rows[i].reply);

      for (int seg = 0; seg < 6; seg++) begin
         drain_responses();
         write_tick_step(seg_steps[seg]);
         send_idle = (seg < 2) ? 13 : (seg < 4) ? 54 : 0;
         recv_idle = (seg < 2) ? 54 : (seg < 4) ? 13 : 0;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)
               op = OP_TICK;
            else if (pick < 50)
               op = OP_ADD;
            else if (pick < 68)
               op = OP_SCHEDULE;
            else if (pick < 76)
               op = OP_CANCEL;
            else if (pick < 92)
               op = OP_EDIT;
            else
               op = OP_UNDEF_A + 3'($urandom_range(2));
            if (tbl_next_id != 0 && $urandom_range(99) < 85)
               id = 4'($urandom_range(int'(tbl_next_id) - 1));
            else
               id = 4'($urandom);
            pick = $urandom_range(9);
            mult = $urandom_range(1, 3);
            if (pick < 4)
               ival = 16'($urandom_range(8));
            else if (pick < 7)
               ival = 16'((tbl_step == 0) ? mult : int'(tbl_step) * mult);
            else if (pick < 9)
               ival = 16'($urandom);
            else
               ival = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            if (seg == 1 && n == 30)
               rsp_hold_req = 1'b1;
            send_request(op, id, ival, 1'b0, '0);
         end
      end

      drain_responses();
      repeat (20) @(negedge clock);
      $display("covered %0d requests: %0d ticks, %0d due flags, %0d table-full adds, %0d bad ids",
               request_count, tick_count, due_flag_count, full_count, unknown_count);
      $display("tick steps 1, 255, 3, 0, 2 and 255, one long response hold-off");
      if (mismatch_count == 0 && sched_reply_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
